### design/pev_pkg.sv
// Shared types, constants and Q16.16 helper functions for the polynomial evaluator.
package pev_pkg;

   // Fixed field widths
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned ORDER_W = 3;
   localparam int unsigned Q_FRAC  = 16;

   // Register indexes on the csr port
   localparam logic [ORDER_W-1:0] CSR_ORDER     = 3'd0;
   localparam logic [ORDER_W-1:0] CSR_COEF_BASE = 3'd1;

   // Q16.16 constants
   localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0001_0000;
   localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

   // Mode codes
   localparam logic MODE_EVAL   = 1'b0;
   localparam logic MODE_POWERS = 1'b1;

   // Saturated value with its overflow flag
   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic                     ovf;
   } sat_type;

   // Shift a full Q16.16 product back to Q16.16 and saturate to 32 bits
   function automatic sat_type q_narrow(input logic signed [2*DATA_W-1:0] p);
      logic signed [2*DATA_W-1:0] q;
      sat_type                    r;
      q     = p >>> Q_FRAC;
      r.ovf = (q[2*DATA_W-1:DATA_W-1] != {(DATA_W+1){q[DATA_W-1]}});
      if (!r.ovf) begin
         r.val = q[DATA_W-1:0];
      end else if (q[2*DATA_W-1]) begin
         r.val = SAT_MIN;
      end else begin
         r.val = SAT_MAX;
      end
      return r;
   endfunction

   // Saturating 32-bit signed add
   function automatic sat_type sat_add(input logic signed [DATA_W-1:0] a,
                                       input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W:0] s;
      sat_type                r;
      s     = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      r.ovf = s[DATA_W] ^ s[DATA_W-1];
      if (!r.ovf) begin
         r.val = s[DATA_W-1:0];
      end else if (s[DATA_W]) begin
         r.val = SAT_MIN;
      end else begin
         r.val = SAT_MAX;
      end
      return r;
   endfunction

endpackage

### design/polynomial_evaluator_unit.sv
// Pipelined Q16.16 power-series evaluator with a power-row serialiser on the output.
// Throughput: evaluate mode takes one beat per cycle unless rsp_tready stalls the output; power
// mode holds the pipeline until the output serialiser, which sends one power per cycle while
// rsp_tready is high, has sent every power of the row.
// Each power step is a multiply stage followed by a shift, saturate and add stage.
// Reset (synchronous) empties the pipeline and clears order and coefficients to zero.
module polynomial_evaluator_unit
   import pev_pkg::*;
#(
   parameter int unsigned MAX_ORDER = 6
) (
   input  logic                clock,
   input  logic                reset,
   // configuration write port
   input  logic                csr_we,
   input  logic [ORDER_W-1:0]  csr_addr,
   input  logic [DATA_W-1:0]   csr_wdata,
   // sample input
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [DATA_W-1:0]   req_tdata,   // [31:0] sample_x
   input  logic                req_tuser,   // [0] mode
   input  logic                req_tlast,   // block_end
   // result output
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DATA_W-1:0]   rsp_tdata,   // [31:0] value
   output logic [4:0]          rsp_tuser,   // [2:0] power_index, [3] overflow,
                                            // [4] block_end_out
   output logic                rsp_tlast    // run_last
);

   localparam int unsigned IDX_W  = $clog2(MAX_ORDER + 1);
   localparam int unsigned LAST_S = 2 * MAX_ORDER;

   typedef struct packed {
      logic                          valid;
      logic                          mode;
      logic                          bend;
      logic signed [DATA_W-1:0]      x;
      logic signed [DATA_W-1:0]      acc;
      logic                          acc_ovf;
      logic [MAX_ORDER:0][DATA_W-1:0] pow;
      logic [MAX_ORDER:0]            pow_ovf;
      logic signed [2*DATA_W-1:0]    prod_c;
      logic signed [2*DATA_W-1:0]    prod_p;
   } stage_type;

   logic [ORDER_W-1:0]       order_ff;
   logic signed [DATA_W-1:0] coef_ff [0:MAX_ORDER];
   logic [IDX_W-1:0]         n_used;

   stage_type                st_ff [0:LAST_S];
   stage_type                st_in [0:LAST_S];
   logic                     advance;

   stage_type                out_ff;
   logic                     out_valid_ff;
   logic [IDX_W-1:0]         beat_ff;
   logic                     out_last;
   logic                     ser_free;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= '0;
         for (int k = 0; k <= MAX_ORDER; k++) begin
            coef_ff[k] <= '0;
         end
      end else if (csr_we) begin
         if (csr_addr == CSR_ORDER) begin
            order_ff <= csr_wdata[ORDER_W-1:0];
         end
         for (int k = 0; k <= MAX_ORDER; k++) begin
            if (csr_addr == CSR_COEF_BASE + ORDER_W'(k)) begin
               coef_ff[k] <= csr_wdata;
            end
         end
      end
   end

   // Clamp the order to the built depth
   always_comb begin
      if (order_ff > ORDER_W'(MAX_ORDER)) begin
         n_used = IDX_W'(MAX_ORDER);
      end else begin
         n_used = order_ff[IDX_W-1:0];
      end
   end

   // Whole pipeline moves together; hold everything while the serialiser is busy and the last stage is full
   assign ser_free   = !out_valid_ff || (rsp_tready && out_last);
   assign advance    = !st_ff[LAST_S].valid || ser_free;
   assign req_tready = advance;

   // Entry stage: seed accumulator with a0 and the power row with 1.0 and x
   always_comb begin
      st_in[0]         = '0;
      st_in[0].valid   = req_tvalid;
      st_in[0].mode    = req_tuser;
      st_in[0].bend    = req_tlast;
      st_in[0].x       = req_tdata;
      st_in[0].acc     = coef_ff[0];
      st_in[0].pow[0]  = Q_ONE;
      st_in[0].pow[1]  = req_tdata;
   end

   // One multiply stage and one saturate/add stage per power
   for (genvar j = 1; j <= MAX_ORDER; j++) begin : g_step
      // Multiply: term product and next power product
      always_comb begin
         st_in[2*j-1]        = st_ff[2*j-2];
         st_in[2*j-1].prod_c = coef_ff[j] * $signed(st_ff[2*j-2].pow[j]);
         st_in[2*j-1].prod_p = $signed(st_ff[2*j-2].pow[j]) * st_ff[2*j-2].x;
      end

      // Narrow, saturate and accumulate; form the next power
      always_comb begin
         sat_type term;
         sat_type sum;
         sat_type pw;
         term      = q_narrow(st_ff[2*j-1].prod_c);
         sum       = sat_add(st_ff[2*j-1].acc, term.val);
         pw        = q_narrow(st_ff[2*j-1].prod_p);
         st_in[2*j] = st_ff[2*j-1];
         if (IDX_W'(j) <= n_used) begin
            st_in[2*j].acc     = sum.val;
            st_in[2*j].acc_ovf = st_ff[2*j-1].acc_ovf | term.ovf | sum.ovf;
         end
         if (j < MAX_ORDER) begin
            st_in[2*j].pow[(j < MAX_ORDER) ? j+1 : j]     = pw.val;
            st_in[2*j].pow_ovf[(j < MAX_ORDER) ? j+1 : j] =
               st_ff[2*j-1].pow_ovf[j] | pw.ovf;
         end
      end
   end

   // Stage registers: valid bits reset, payload only loads
   for (genvar s = 0; s <= LAST_S; s++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[s].valid <= 1'b0;
         end else if (advance) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   // Output serialiser: load a finished item, then step through its beats
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         beat_ff      <= '0;
      end else if (ser_free) begin
         out_valid_ff <= st_ff[LAST_S].valid;
         beat_ff      <= '0;
      end else if (rsp_tready) begin
         beat_ff      <= beat_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_free) begin
         out_ff <= st_ff[LAST_S];
      end
   end

   // Drive the result beat
   always_comb begin
      logic ovf;
      out_last = (out_ff.mode == MODE_EVAL) || (beat_ff == n_used);
      if (out_ff.mode == MODE_POWERS) begin
         rsp_tdata      = out_ff.pow[beat_ff];
         rsp_tuser[2:0] = ORDER_W'(beat_ff);
         ovf            = out_ff.pow_ovf[beat_ff];
      end else begin
         rsp_tdata      = out_ff.acc;
         rsp_tuser[2:0] = '0;
         ovf            = out_ff.acc_ovf | out_ff.pow_ovf[n_used];
      end
      rsp_tuser[3] = ovf;
      rsp_tuser[4] = out_last & out_ff.bend;
      rsp_tlast    = out_last;
      rsp_tvalid   = out_valid_ff;
   end

endmodule

### dv/tb.sv
// Self-checking stream testbench for the polynomial evaluator unit.
module tb
   import pev_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          ORDER_CAP     = 6;
   localparam int          SETTLE_CYCLES = 2 * ORDER_CAP + 2 + 16;
   localparam int unsigned CYCLE_LIMIT   = 600_000;
   localparam int          MAX_REPORTS   = 10;
   localparam int          RANDOM_PHASES = 8;
   localparam int          PHASE_ITEMS   = 58;

   localparam logic signed [63:0] Q_HI = 64'sd2147483647;
   localparam logic signed [63:0] Q_LO = -64'sd2147483648;

   // One sample beat as the sender sees it
   typedef struct packed {
      logic        mode;
      logic [31:0] x;
      logic        bend;
   } sample_type;

   // One result beat, unpacked into its fields
   typedef struct packed {
      logic [31:0] value;
      logic [2:0]  pidx;
      logic        last;
      logic        ovf;
      logic        bend;
   } poly_result_type;

   // Saturated Q16.16 value with its overflow mark
   typedef struct packed {
      logic signed [31:0] v;
      logic               sat;
   } qval_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        csr_we    = 1'b0;
   logic [2:0]  csr_addr  = '0;
   logic [31:0] csr_wdata = '0;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] sample_x
   logic        req_tuser  = 1'b0; // [0] mode
   logic        req_tlast  = 1'b0; // block_end

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] value
   logic [4:0]  rsp_tuser;         // [2:0] power_index, [3] overflow, [4] block_end_out
   logic        rsp_tlast;         // run_last

   // Shadow of the register file as the block should hold it
   logic [2:0]         order_reg = '0;
   logic signed [31:0] coef_reg [0:6];

   sample_type      sample_q[$];
   poly_result_type expected_q[$];

   int unsigned gap_left    = 0;
   int unsigned stall_left  = 0;
   bit          snd_burst   = 1'b0;
   bit          rcv_burst   = 1'b0;
   int unsigned cycle_count = 0;

   int unsigned mismatch_count = 0;
   int unsigned n_eval         = 0;
   int unsigned n_power        = 0;
   int unsigned n_beats        = 0;
   int unsigned n_ovf          = 0;
   int unsigned n_settings     = 0;

   polynomial_evaluator_unit #(.MAX_ORDER(ORDER_CAP)) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Clamp a wide intermediate to the signed 32-bit range
   function automatic qval_type clamp_q(input logic signed [63:0] w);
      qval_type r;
      if (w > Q_HI) begin
         r.v   = SAT_MAX;
         r.sat = 1'b1;
      end else if (w < Q_LO) begin
         r.v   = SAT_MIN;
         r.sat = 1'b1;
      end else begin
         r.v   = w[31:0];
         r.sat = 1'b0;
      end
      return r;
   endfunction

   // Exact product, floor shift back to Q16.16, then clamp
   function automatic qval_type q_mul(input logic signed [31:0] a, input logic signed [31:0] b);
      logic signed [63:0] wa;
      logic signed [63:0] wb;
      wa = a;
      wb = b;
      return clamp_q((wa * wb) >>> Q_FRAC);
   endfunction

   function automatic qval_type q_add(input logic signed [31:0] a, input logic signed [31:0] b);
      logic signed [63:0] wa;
      logic signed [63:0] wb;
      wa = a;
      wb = b;
      return clamp_q(wa + wb);
   endfunction

   // Work out the result beats that one accepted sample must produce
   function automatic void predict_sample(input logic mode, input logic signed [31:0] x,
                                          input logic bend);
      int                 n;
      logic               ovf;
      logic signed [31:0] acc;
      logic signed [31:0] px;
      qval_type           t;
      n   = (int'(order_reg) > ORDER_CAP) ? ORDER_CAP : int'(order_reg);
      ovf = 1'b0;
      if (mode == MODE_EVAL) begin
         // power series: the last power is never formed beyond x^n
         acc = coef_reg[0];
         px  = x;
         for (int j = 1; j <= n; j++) begin
            t   = q_mul(coef_reg[j], px);
            ovf |= t.sat;
            t   = q_add(acc, t.v);
            ovf |= t.sat;
            acc = t.v;
            if (j < n) begin
               t   = q_mul(px, x);
               ovf |= t.sat;
               px  = t.v;
            end
         end
         expected_q.push_back('{value: acc, pidx: 3'd0, last: 1'b1, ovf: ovf, bend: bend});
      end else begin
         // power row: flag stays set once any power has clamped
         px = Q_ONE;
         for (int j = 0; j <= n; j++) begin
            if (j > 0) begin
               t   = q_mul(px, x);
               ovf |= t.sat;
               px  = t.v;
            end
            expected_q.push_back('{value: px, pidx: 3'(j), last: (j == n), ovf: ovf,
                                   bend: (j == n) ? bend : 1'b0});
         end
      end
   endfunction

   // Mix of extremes, unit values, full-range words and small magnitudes
   function automatic logic [31:0] pick_fixed();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 11))
         0:       return SAT_MAX;
         1:       return SAT_MIN;
         2:       return r[0] ? Q_ONE : -Q_ONE;
         3, 4:    return r;
         5, 6:    return {{10{r[21]}}, r[21:0]};
         7, 8, 9: return {{14{r[17]}}, r[17:0]};
         default: return {{24{r[7]}}, r[7:0]};
      endcase
   endfunction

   task automatic push_sample(input logic mode, input logic [31:0] x, input logic bend);
      sample_q.push_back('{mode: mode, x: x, bend: bend});
   endtask

   // Write one register; the shadow follows at the same edge
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_ORDER) begin
         order_reg = val[2:0];
         n_settings++;
      end else begin
         coef_reg[idx - CSR_COEF_BASE] = val;
      end
   endtask

   // Order write with junk in the unused upper bits half of the time
   task automatic write_order(input logic [2:0] ord);
      logic [31:0] hi;
      hi = $urandom_range(0, 1) ? ($urandom & ~32'h7) : 32'h0;
      write_reg(CSR_ORDER, hi | 32'(ord));
   endtask

   // Hold until every queued sample is taken and every result is back, then settle
   task automatic wait_pipeline_empty();
      do @(negedge clock);
      while (sample_q.size() != 0 || req_tvalid || expected_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Present queued samples; predict each beat at the edge that accepts it
   always @(posedge clock) begin : sample_driver
      sample_type s;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_sample(req_tuser, req_tdata, req_tlast);
            if (req_tuser == MODE_EVAL) n_eval++;
            else n_power++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               req_tvalid <= 1'b0;
               gap_left   <= gap_left - 1;
            end else if (sample_q.size() != 0) begin
               s = sample_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= s.mode;
               req_tdata  <= s.x;
               req_tlast  <= s.bend;
               if ($urandom_range(0, 11) == 0) snd_burst = !snd_burst;
               gap_left <= snd_burst ? 0 : $urandom_range(0, 18);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Take result beats with random back-pressure and compare against the predictions
   always @(posedge clock) begin : result_monitor
      poly_result_type seen;
      poly_result_type want;
      int unsigned     stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         stall = stall_left;
         if (rsp_tvalid && rsp_tready) begin
            seen = '{value: rsp_tdata, pidx: rsp_tuser[2:0], last: rsp_tlast,
                     ovf: rsp_tuser[3], bend: rsp_tuser[4]};
            n_beats++;
            if (seen.ovf) n_ovf++;
            if (expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("[%0d] unexpected result beat: value %h idx %0d last %b ovf %b end %b",
                           cycle_count, seen.value, seen.pidx, seen.last, seen.ovf, seen.bend);
            end else begin
               want = expected_q.pop_front();
               if (seen.value !== want.value || seen.pidx !== want.pidx ||
                   seen.last !== want.last || seen.ovf !== want.ovf ||
                   seen.bend !== want.bend) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("[%0d] result beat %0d differs", cycle_count, n_beats);
                     $display("   expected value %h idx %0d last %b ovf %b end %b",
                              want.value, want.pidx, want.last, want.ovf, want.bend);
                     $display("   actual   value %h idx %0d last %b ovf %b end %b",
                              seen.value, seen.pidx, seen.last, seen.ovf, seen.bend);
                  end
               end
            end
            if ($urandom_range(0, 11) == 0) rcv_burst = !rcv_burst;
            stall = rcv_burst ? 0 : $urandom_range(0, 18);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall - 1;
         end else begin
            rsp_tready <= 1'b1;
            stall_left <= 0;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles, %0d result beats outstanding",
                  cycle_count, expected_q.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      logic [2:0] ord;
      for (int k = 0; k <= ORDER_CAP; k++) coef_reg[k] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset values: order zero, all coefficients zero
      @(negedge clock);
      push_sample(MODE_EVAL, SAT_MAX, 1'b0);
      push_sample(MODE_POWERS, SAT_MIN, 1'b1);
      push_sample(MODE_EVAL, 32'hFFFF_FFFF, 1'b1);
      wait_pipeline_empty();

      // Order above the cap with extreme coefficients
      write_reg(CSR_COEF_BASE + 3'd0, SAT_MAX);
      write_reg(CSR_COEF_BASE + 3'd1, SAT_MIN);
      write_reg(CSR_COEF_BASE + 3'd2, Q_ONE);
      write_reg(CSR_COEF_BASE + 3'd3, -Q_ONE);
      write_reg(CSR_COEF_BASE + 3'd4, 32'h0000_8000);
      write_reg(CSR_COEF_BASE + 3'd5, 32'hFFFF_FFFF);
      write_reg(CSR_COEF_BASE + 3'd6, 32'h0003_0000);
      write_order(3'd7);
      @(negedge clock);
      push_sample(MODE_EVAL, 32'h0, 1'b0);
      push_sample(MODE_EVAL, Q_ONE, 1'b0);
      push_sample(MODE_EVAL, -Q_ONE, 1'b1);
      push_sample(MODE_EVAL, SAT_MAX, 1'b0);
      push_sample(MODE_EVAL, SAT_MIN, 1'b1);
      push_sample(MODE_EVAL, 32'hFFFF_FFFF, 1'b0);
      push_sample(MODE_EVAL, 32'h0000_0001, 1'b0);
      push_sample(MODE_EVAL, 32'h0001_8000, 1'b1);
      push_sample(MODE_EVAL, 32'h0100_0000, 1'b0);
      push_sample(MODE_POWERS, SAT_MAX, 1'b1);
      push_sample(MODE_POWERS, 32'hFFFF_FFFF, 1'b0);
      push_sample(MODE_POWERS, 32'hFFFE_8000, 1'b1);
      push_sample(MODE_POWERS, 32'h0100_0000, 1'b0);
      wait_pipeline_empty();

      // Order zero: constant term only, power row is just 1.0
      write_reg(CSR_COEF_BASE, 32'h1234_5678);
      write_order(3'd0);
      @(negedge clock);
      push_sample(MODE_EVAL, $urandom, 1'b1);
      push_sample(MODE_POWERS, SAT_MAX, 1'b1);
      wait_pipeline_empty();

      // Order one: a huge x must not flag when no square is formed
      write_reg(CSR_COEF_BASE, 32'h0);
      write_reg(CSR_COEF_BASE + 3'd1, 32'h0000_0001);
      write_order(3'd1);
      @(negedge clock);
      push_sample(MODE_EVAL, SAT_MIN, 1'b1);
      push_sample(MODE_POWERS, SAT_MIN, 1'b0);

      // Random phases; each boundary drains the block before new settings go in
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_pipeline_empty();
         case (ph)
            0:       ord = 3'd6;
            1:       ord = 3'd7;
            2:       ord = 3'd0;
            3:       ord = 3'd1;
            default: ord = 3'($urandom_range(0, 7));
         endcase
         for (int k = 0; k <= ORDER_CAP; k++)
            write_reg(CSR_COEF_BASE + 3'(k), pick_fixed());
         write_order(ord);
         @(negedge clock);
         for (int i = 0; i < PHASE_ITEMS; i++)
            push_sample($urandom_range(0, 1) ? MODE_POWERS : MODE_EVAL, pick_fixed(),
                        $urandom_range(0, 3) == 0);
      end

      wait_pipeline_empty();
      $display("Covered %0d samples (%0d evaluate, %0d power row) giving %0d result beats",
               n_eval + n_power, n_eval, n_power, n_beats);
      $display("%0d beats carried overflow, %0d order settings used, %0d beats disagreed",
               n_ovf, n_settings, mismatch_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
